// ===== rtl/pgbt_pkg.sv =====
// Shared constants, codes and types of the PIM group busy tracker.
package pgbt_pkg;

    localparam int NUM_GROUPS   = 4;
    localparam int GROUP_ARRAYS = 8;
    localparam int ARRAY_BLOCKS = 16;
    localparam int BLOCK_ROWS   = 32;

    localparam int MASK_ENTRIES = NUM_GROUPS * GROUP_ARRAYS * ARRAY_BLOCKS;

    localparam int GRP_W      = 2;
    localparam int ARR_W      = 3;
    localparam int BLK_W      = 4;
    localparam int ADDR_W     = GRP_W + ARR_W + BLK_W;
    localparam int MASK_W     = 32;
    localparam int TIME_W     = 32;
    localparam int MODE_W     = 4;
    localparam int SEL_W      = 10;
    localparam int SUM_W      = SEL_W + 1;
    localparam int COST_W     = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [MASK_W-1:0] ROW_LIVE  = {MASK_W{1'b1}} >> (MASK_W - BLOCK_ROWS);
    localparam logic [SEL_W-1:0]  ROWS_SAT  = {SEL_W{1'b1}};
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MASK_ENTRIES - 1);
    localparam logic [BLK_W-1:0]  BLK_LAST  = BLK_W'(ARRAY_BLOCKS - 1);

    localparam logic [MODE_W-1:0] MODE_CHECK        = 4'd0;
    localparam logic [MODE_W-1:0] MODE_NOR          = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SET          = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MASK         = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MUL_RD       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MV_SINGLE    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_RD_SINGLE    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_WRITE_SINGLE = 4'd7;
    localparam logic [MODE_W-1:0] MODE_WRITE_MUL    = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_COST        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARRAY_READ_ROW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRAY_READ_BUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_SINGLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SINGLE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SINGLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_MULTI_ROW  = 3'd6;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_DRAIN,
        S_COST,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              clr_wr;
        logic              rd_en;
        logic              calc_cost;
        logic              update;
        logic [ADDR_W-1:0] cnt;
    } t_ctrl_cmd;

    typedef struct packed {
        logic whole_read;
        logic one_read;
    } t_dp_status;

endpackage

// ===== rtl/pgbt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module pgbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pgbt_ctrl.sv =====
// Controller state machine that sequences clearing, mask reads, cost and update.
module pgbt_ctrl
    import pgbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CLR_LAST) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_cnt = '0;
                if (i_status.whole_read || i_status.one_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_COST;
                end
            end
            S_READ: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (i_status.one_read || (r_cnt[BLK_W-1:0] == BLK_LAST)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COST;
            end
            S_COST: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load      = (r_state == S_IDLE) && i_start;
        o_cmd.clr_wr    = (r_state == S_CLEAR);
        o_cmd.rd_en     = (r_state == S_READ);
        o_cmd.calc_cost = (r_state == S_COST);
        o_cmd.update    = (r_state == S_UPDATE);
        o_cmd.cnt       = r_cnt;
        o_busy          = (r_state != S_IDLE);
    end

endmodule

// ===== rtl/pgbt_datapath.sv =====
// Datapath with command latches, cost registers, mask store, popcount sum and busy table.
module pgbt_datapath
    import pgbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [TIME_W-1:0]     i_now,
    input  logic [GRP_W-1:0]      i_group_index,
    input  logic [ARR_W-1:0]      i_array_index,
    input  logic [BLK_W-1:0]      i_block_index,
    input  logic                  i_one_block,
    input  logic [MASK_W-1:0]     i_mask_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic                  o_group_busy,
    output logic [TIME_W-1:0]     o_busy_until,
    output logic [SEL_W-1:0]      o_selected_rows
);

    logic [MODE_W-1:0] r_mode;
    logic [TIME_W-1:0] r_now;
    logic [GRP_W-1:0]  r_grp;
    logic [ARR_W-1:0]  r_arr;
    logic [BLK_W-1:0]  r_blk;
    logic              r_one;
    logic [MASK_W-1:0] r_mval;

    logic [7:0] r_mask_cost;
    logic [7:0] r_rd_row_cost;
    logic [7:0] r_rd_bus_cost;
    logic [8:0] r_mv_cost;
    logic [7:0] r_rd_cost;
    logic [7:0] r_ws_cost;
    logic [7:0] r_wm_row_cost;

    logic [TIME_W-1:0] r_busy_tbl [NUM_GROUPS];
    logic              r_rd_vld;
    logic [SEL_W-1:0]  r_sum;
    logic [COST_W-1:0] r_cost;
    logic              r_apply;
    logic              r_done;
    logic              r_group_busy;
    logic [TIME_W-1:0] r_busy_until;
    logic [SEL_W-1:0]  r_sel_out;

    logic              is_multi;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [MASK_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [MASK_W-1:0] ram_rdata;
    logic [SUM_W-1:0]  sum_next;
    logic [SEL_W-1:0]  sel1;
    logic [COST_W-1:0] n_cost;
    logic              n_apply;
    logic [TIME_W-1:0] busy_old;
    logic [TIME_W:0]   t_sum;
    logic [TIME_W-1:0] t_sat;
    logic [TIME_W-1:0] busy_new;

    function automatic logic [5:0] popcount(input logic [MASK_W-1:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++) begin
            n = n + 6'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [8:0] max1(input logic [8:0] v);
        return (v == '0) ? 9'd1 : v;
    endfunction

    assign is_multi = (r_mode == MODE_MUL_RD) || (r_mode == MODE_WRITE_MUL);
    assign o_status.whole_read = is_multi && !r_one;
    assign o_status.one_read   = (r_mode == MODE_NOR) || (r_mode == MODE_SET) ||
                                 (is_multi && r_one);

    assign ram_we    = i_cmd.clr_wr || (i_cmd.calc_cost && (r_mode == MODE_MASK));
    assign ram_waddr = i_cmd.clr_wr ? i_cmd.cnt : {r_grp, r_arr, r_blk};
    assign ram_wdata = i_cmd.clr_wr ? {MASK_W{1'b1}} : r_mval;
    assign ram_raddr = {r_grp, r_arr, o_status.whole_read ? i_cmd.cnt[BLK_W-1:0] : r_blk};

    pgbt_ram #(
        .WIDTH (MASK_W),
        .DEPTH (MASK_ENTRIES)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_now  <= i_now;
            r_grp  <= i_group_index;
            r_arr  <= i_array_index;
            r_blk  <= i_block_index;
            r_one  <= i_one_block;
            r_mval <= i_mask_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_cost   <= 8'd1;
            r_rd_row_cost <= 8'd16;
            r_rd_bus_cost <= 8'd4;
            r_mv_cost     <= 9'd17;
            r_rd_cost     <= 8'd1;
            r_ws_cost     <= 8'd1;
            r_wm_row_cost <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MASK_COST:       r_mask_cost   <= i_cfg_data[7:0];
                REG_ARRAY_READ_ROW:  r_rd_row_cost <= i_cfg_data[7:0];
                REG_ARRAY_READ_BUS:  r_rd_bus_cost <= i_cfg_data[7:0];
                REG_MOVE_SINGLE:     r_mv_cost     <= i_cfg_data;
                REG_READ_SINGLE:     r_rd_cost     <= i_cfg_data[7:0];
                REG_WRITE_SINGLE:    r_ws_cost     <= i_cfg_data[7:0];
                REG_WRITE_MULTI_ROW: r_wm_row_cost <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign sum_next = SUM_W'(r_sum) + SUM_W'(popcount(ram_rdata & ROW_LIVE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
        if (i_cmd.load) begin
            r_sum <= '0;
        end else if (r_rd_vld) begin
            r_sum <= (sum_next > SUM_W'(ROWS_SAT)) ? ROWS_SAT : sum_next[SEL_W-1:0];
        end
    end

    assign sel1 = (r_sum == '0) ? SEL_W'(1) : r_sum;

    always_comb begin
        n_cost  = '0;
        n_apply = 1'b1;
        case (r_mode)
            MODE_NOR, MODE_SET: n_cost = COST_W'(sel1);
            MODE_MASK:          n_cost = COST_W'(r_mask_cost);
            MODE_MUL_RD:        n_cost = COST_W'(max1({1'b0, r_rd_row_cost})) * COST_W'(sel1)
                                       + COST_W'(max1({1'b0, r_rd_bus_cost}));
            MODE_MV_SINGLE:     n_cost = COST_W'(max1(r_mv_cost));
            MODE_RD_SINGLE:     n_cost = COST_W'(max1({1'b0, r_rd_cost}));
            MODE_WRITE_SINGLE:  n_cost = COST_W'(r_ws_cost);
            MODE_WRITE_MUL:     n_cost = COST_W'(max1({1'b0, r_wm_row_cost})) * COST_W'(sel1);
            default:            n_apply = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_cost) begin
            r_cost  <= n_cost;
            r_apply <= n_apply;
        end
    end

    assign busy_old = r_busy_tbl[r_grp];
    assign t_sum    = {1'b0, r_now} + (TIME_W + 1)'(r_cost);
    assign t_sat    = t_sum[TIME_W] ? {TIME_W{1'b1}} : t_sum[TIME_W-1:0];
    assign busy_new = (r_apply && (t_sat > busy_old)) ? t_sat : busy_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_busy_tbl[g] <= '0;
            end
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
            if (i_cmd.update) begin
                r_busy_tbl[r_grp] <= busy_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_group_busy <= (busy_old > r_now);
            r_busy_until <= busy_new;
            r_sel_out    <= r_sum;
        end
    end

    assign o_done          = r_done;
    assign o_group_busy    = r_group_busy;
    assign o_busy_until    = r_busy_until;
    assign o_selected_rows = r_sel_out;

endmodule

// ===== rtl/pim_group_busy_tracker_unit.sv =====
// Top level of the PIM group busy tracker: controller and datapath.
//
// A command transaction is accepted at a clock edge where start is high and
// busy is low. The fields of the command are sampled at that edge.
// Each transaction gives one result on o_group_busy, o_busy_until and
// o_selected_rows, marked by o_done, which is high for exactly one cycle;
// the outputs keep that result until the next one. A command passes
// through dispatch, mask reads, drain, cost and update; commands without
// a mask read go straight from dispatch to cost. Whole-array commands use
// the single read port of the mask memory, which delivers one block mask
// per cycle for all 16 blocks. One command is in flight at a time, and the
// next one can be accepted in the cycle that shows the result.
// After reset the block sweeps all 512 entries of the mask memory to all
// ones, one entry per cycle, and holds busy high during the sweep. Cost
// registers are written through i_cfg_we, i_cfg_idx and i_cfg_data at an
// edge outside reset; the user must do so only while no command is in
// flight, which the block itself does not enforce. The receiver cannot
// stall the block, so results never wait for it.
module pim_group_busy_tracker_unit
    import pgbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [TIME_W-1:0]     i_now,
    input  logic [GRP_W-1:0]      i_group_index,
    input  logic [ARR_W-1:0]      i_array_index,
    input  logic [BLK_W-1:0]      i_block_index,
    input  logic                  i_one_block,
    input  logic [MASK_W-1:0]     i_mask_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic                  o_group_busy,
    output logic [TIME_W-1:0]     o_busy_until,
    output logic [SEL_W-1:0]      o_selected_rows
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    pgbt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pgbt_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (i_mode),
        .i_now           (i_now),
        .i_group_index   (i_group_index),
        .i_array_index   (i_array_index),
        .i_block_index   (i_block_index),
        .i_one_block     (i_one_block),
        .i_mask_value    (i_mask_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_group_busy    (o_group_busy),
        .o_busy_until    (o_busy_until),
        .o_selected_rows (o_selected_rows)
    );

endmodule

// ===== test/pim_group_busy_tracker_unit_tb.sv =====
// Self-checking testbench for the PIM group busy tracker with a built-in busy-time predictor.
module pim_group_busy_tracker_unit_tb;
    import pgbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 30;
    localparam int EXP_DEPTH      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_UNUSED_LO = 4'd9;
    localparam logic [MODE_W-1:0]    MODE_UNUSED_HI = 4'd15;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] now;
        logic [GRP_W-1:0]  grp;
        logic [ARR_W-1:0]  arr;
        logic [BLK_W-1:0]  blk;
        logic              one_block;
        logic [MASK_W-1:0] mask;
    } t_pim_cmd;

    typedef struct {
        logic              group_busy;
        logic [TIME_W-1:0] busy_until;
        logic [SEL_W-1:0]  sel_rows;
    } t_busy_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     i_mode;
    logic [TIME_W-1:0]     i_now;
    logic [GRP_W-1:0]      i_group_index;
    logic [ARR_W-1:0]      i_array_index;
    logic [BLK_W-1:0]      i_block_index;
    logic                  i_one_block;
    logic [MASK_W-1:0]     i_mask_value;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic                  o_group_busy;
    logic [TIME_W-1:0]     o_busy_until;
    logic [SEL_W-1:0]      o_selected_rows;

    logic [MASK_W-1:0]     row_mask_mem [MASK_ENTRIES];
    logic [TIME_W-1:0]     busy_until_mem [NUM_GROUPS];
    logic [CFG_DATA_W-1:0] cost_reg [7];
    logic [CFG_DATA_W-1:0] cfg_plan [8];

    t_busy_result expected_mem [EXP_DEPTH];
    int           exp_wr;
    int           exp_rd;
    int           err_cnt;
    int           idle_cycles;
    int           sender_idle_pct;
    logic [TIME_W-1:0] time_base;
    t_pim_cmd     last_target;

    pim_group_busy_tracker_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_now           (i_now),
        .i_group_index   (i_group_index),
        .i_array_index   (i_array_index),
        .i_block_index   (i_block_index),
        .i_one_block     (i_one_block),
        .i_mask_value    (i_mask_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_group_busy    (o_group_busy),
        .o_busy_until    (o_busy_until),
        .o_selected_rows (o_selected_rows)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_at_one(logic [63:0] v);
        return (v == 64'd0) ? 64'd1 : v;
    endfunction

    function automatic int unsigned rows_of(int unsigned entry);
        return $countones(row_mask_mem[entry] & ROW_LIVE);
    endfunction

    function automatic t_busy_result compute_busy_result(t_pim_cmd c);
        t_busy_result r;
        logic [TIME_W-1:0] held;
        logic [63:0]       cost;
        logic [63:0]       t;
        int unsigned       sel;
        int unsigned       base;
        bit                apply;
        held  = busy_until_mem[c.grp];
        base  = (int'(c.grp) * GROUP_ARRAYS + int'(c.arr)) * ARRAY_BLOCKS;
        sel   = 0;
        cost  = 64'd0;
        apply = 1'b1;
        r.group_busy = (held > c.now);
        if (c.mode == MODE_MUL_RD || c.mode == MODE_WRITE_MUL) begin
            if (c.one_block) begin
                sel = rows_of(base + c.blk);
            end else begin
                for (int k = 0; k < ARRAY_BLOCKS; k++) sel += rows_of(base + k);
            end
        end else if (c.mode == MODE_NOR || c.mode == MODE_SET) begin
            sel = rows_of(base + c.blk);
        end
        if (sel > 32'(ROWS_SAT)) sel = 32'(ROWS_SAT);
        case (c.mode)
            MODE_NOR, MODE_SET: cost = floor_at_one(64'(sel));
            MODE_MASK: begin
                row_mask_mem[base + c.blk] = c.mask;
                cost = 64'(cost_reg[REG_MASK_COST]);
            end
            MODE_MUL_RD: cost = floor_at_one(64'(cost_reg[REG_ARRAY_READ_ROW]))
                              * floor_at_one(64'(sel))
                              + floor_at_one(64'(cost_reg[REG_ARRAY_READ_BUS]));
            MODE_MV_SINGLE: cost = floor_at_one(64'(cost_reg[REG_MOVE_SINGLE]));
            MODE_RD_SINGLE: cost = floor_at_one(64'(cost_reg[REG_READ_SINGLE]));
            MODE_WRITE_SINGLE: cost = 64'(cost_reg[REG_WRITE_SINGLE]);
            MODE_WRITE_MUL: cost = floor_at_one(64'(cost_reg[REG_WRITE_MULTI_ROW]))
                                 * floor_at_one(64'(sel));
            default: apply = 1'b0;
        endcase
        if (apply) begin
            t = 64'(c.now) + cost;
            if (t > 64'hffff_ffff) t = 64'hffff_ffff;
            if (t > 64'(held)) held = t[TIME_W-1:0];
            busy_until_mem[c.grp] = held;
        end
        r.busy_until = held;
        r.sel_rows   = sel[SEL_W-1:0];
        return r;
    endfunction

    function automatic t_pim_cmd make_cmd(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] now,
                                          int g, int a, int b, logic ob,
                                          logic [MASK_W-1:0] mask);
        t_pim_cmd c;
        c.mode      = mode;
        c.now       = now;
        c.grp       = g[GRP_W-1:0];
        c.arr       = a[ARR_W-1:0];
        c.blk       = b[BLK_W-1:0];
        c.one_block = ob;
        c.mask      = mask;
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_busy_result got;
        t_busy_result want;
        if (i_rst_n && o_done) begin
            got.group_busy = o_group_busy;
            got.busy_until = o_busy_until;
            got.sel_rows   = o_selected_rows;
            if (exp_wr == exp_rd) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("Unexpected result: busy=%b until=%h rows=%0d",
                             got.group_busy, got.busy_until, got.sel_rows);
            end else begin
                want = expected_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.group_busy !== want.group_busy || got.busy_until !== want.busy_until ||
                    got.sel_rows !== want.sel_rows) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"Mismatch: expected busy=%b until=%h rows=%0d, ",
                                  "got busy=%b until=%h rows=%0d"},
                                 want.group_busy, want.busy_until, want.sel_rows,
                                 got.group_busy, got.busy_until, got.sel_rows);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_cmd(input t_pim_cmd c);
        @(negedge i_clk);
        start         <= 1'b1;
        i_mode        <= c.mode;
        i_now         <= c.now;
        i_group_index <= c.grp;
        i_array_index <= c.arr;
        i_block_index <= c.blk;
        i_one_block   <= c.one_block;
        i_mask_value  <= c.mask;
        do @(posedge i_clk); while (busy);
        expected_mem[exp_wr % EXP_DEPTH] = compute_busy_result(c);
        exp_wr++;
    endtask

    task automatic pause_sender();
        if ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 24)) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    task automatic program_costs();
        wait_for_results();
        for (int i = 0; i < 8; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[CFG_IDX_W-1:0];
            i_cfg_data <= cfg_plan[i];
            @(posedge i_clk);
            if (i[CFG_IDX_W-1:0] != REG_UNUSED)
                cost_reg[i] = cfg_plan[i] &
                              ((i[CFG_IDX_W-1:0] == REG_MOVE_SINGLE) ? 9'h1ff : 9'h0ff);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return MASK_W'(1) << $urandom_range(MASK_W - 1);
            3: return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] MODE_MODE_PICK(int unsigned v);
        return v[MODE_W-1:0];
    endfunction

    function automatic t_pim_cmd random_cmd();
        t_pim_cmd c;
        int       pick;
        pick = $urandom_range(99);
        if ($urandom_range(49) == 0) time_base += $urandom_range(0, 200000);
        time_base += $urandom_range(0, 20);
        c = last_target;
        if ($urandom_range(9) < 4) begin
            c.grp = GRP_W'($urandom);
            c.arr = ARR_W'($urandom);
            c.blk = BLK_W'($urandom);
        end else if ($urandom_range(1) == 0) begin
            c.blk = BLK_W'($urandom);
        end
        c.one_block = 1'($urandom);
        c.mask      = random_mask();
        c.now       = time_base + $urandom_range(0, 15);
        if (pick < 5) begin
            c.mode = $urandom_range(1) ? MODE_CHECK
                                       : MODE_MODE_PICK($urandom_range(MODE_UNUSED_LO,
                                                                       MODE_UNUSED_HI));
            c.now  = $urandom;
        end else if (pick < 13) begin
            c.mode = MODE_CHECK;
        end else if (pick < 17) begin
            c.mode = MODE_MODE_PICK($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end else if (pick < 37) begin
            c.mode = MODE_MASK;
        end else if (pick < 52) begin
            c.mode = $urandom_range(1) ? MODE_NOR : MODE_SET;
        end else if (pick < 67) begin
            c.mode = MODE_MUL_RD;
        end else if (pick < 82) begin
            c.mode = MODE_WRITE_MUL;
        end else begin
            case ($urandom_range(2))
                0: c.mode = MODE_MV_SINGLE;
                1: c.mode = MODE_RD_SINGLE;
                default: c.mode = MODE_WRITE_SINGLE;
            endcase
        end
        last_target = c;
        return c;
    endfunction

    task automatic test_default_costs();
        issue_cmd(make_cmd(MODE_CHECK, 32'd0, 0, 0, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_NOR, 32'd10, 0, 0, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_CHECK, 32'd20, 0, 0, 0, 1'b1, '1));
        issue_cmd(make_cmd(MODE_MUL_RD, 32'd0, 1, 7, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_MASK, 32'd100, 2, 3, 15, 1'b1, '0));
        issue_cmd(make_cmd(MODE_SET, 32'd200, 2, 3, 15, 1'b0, '0));
        issue_cmd(make_cmd(MODE_MUL_RD, 32'd300, 2, 3, 15, 1'b1, '0));
        issue_cmd(make_cmd(MODE_WRITE_MUL, 32'd400, 2, 3, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_MASK, 32'd500, 2, 3, 0, 1'b0, 32'ha5a5_0001));
        issue_cmd(make_cmd(MODE_WRITE_MUL, 32'd600, 2, 3, 0, 1'b1, '0));
        issue_cmd(make_cmd(MODE_MV_SINGLE, 32'd50, 3, 7, 15, 1'b0, '0));
        issue_cmd(make_cmd(MODE_RD_SINGLE, 32'd50, 3, 0, 0, 1'b1, '0));
        issue_cmd(make_cmd(MODE_WRITE_SINGLE, 32'd90, 3, 4, 9, 1'b0, '1));
        issue_cmd(make_cmd(MODE_UNUSED_LO, 32'd90, 3, 4, 9, 1'b0, '1));
        issue_cmd(make_cmd(MODE_UNUSED_HI, 32'hffff_ffff, 2, 3, 0, 1'b1, '1));
    endtask

    task automatic test_zero_costs();
        foreach (cfg_plan[i]) cfg_plan[i] = '0;
        program_costs();
        issue_cmd(make_cmd(MODE_MASK, 32'd1000, 2, 3, 15, 1'b0, '0));
        issue_cmd(make_cmd(MODE_WRITE_SINGLE, 32'd1001, 1, 0, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_MUL_RD, 32'd1000000, 2, 3, 15, 1'b1, '0));
        issue_cmd(make_cmd(MODE_WRITE_MUL, 32'd2000000, 2, 3, 15, 1'b1, '0));
        issue_cmd(make_cmd(MODE_MV_SINGLE, 32'd2000000, 3, 1, 1, 1'b0, '0));
        issue_cmd(make_cmd(MODE_RD_SINGLE, 32'd3000000, 3, 1, 1, 1'b0, '0));
    endtask

    task automatic test_max_costs();
        foreach (cfg_plan[i]) cfg_plan[i] = '1;
        program_costs();
        issue_cmd(make_cmd(MODE_MUL_RD, 32'd4000000, 1, 7, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_MV_SINGLE, 32'd5000000, 0, 2, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_WRITE_MUL, 32'd6000000, 3, 6, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_WRITE_SINGLE, 32'd7000000, 2, 5, 5, 1'b1, '0));
    endtask

    task automatic test_random_phase(input int idle_pct, input int count);
        sender_idle_pct = idle_pct;
        foreach (cfg_plan[i])
            cfg_plan[i] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(0, 511))
                                                  : CFG_DATA_W'($urandom_range(0, 12));
        program_costs();
        repeat (count) begin
            pause_sender();
            issue_cmd(random_cmd());
        end
        sender_idle_pct = 0;
    endtask

    task automatic test_time_saturation();
        issue_cmd(make_cmd(MODE_MUL_RD, 32'hffff_fff0, 0, 1, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_CHECK, 32'hffff_ffff, 0, 1, 0, 1'b0, '0));
        issue_cmd(make_cmd(MODE_MASK, 32'hffff_ffff, 1, 2, 3, 1'b1, 32'h8000_0000));
        issue_cmd(make_cmd(MODE_CHECK, 32'hffff_fffe, 1, 0, 0, 1'b0, '0));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_mode          = MODE_CHECK;
        i_now           = '0;
        i_group_index   = '0;
        i_array_index   = '0;
        i_block_index   = '0;
        i_one_block     = 1'b0;
        i_mask_value    = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_MASK_COST;
        i_cfg_data      = '0;
        exp_wr          = 0;
        exp_rd          = 0;
        err_cnt         = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        time_base       = 32'd10_000_000;
        last_target     = make_cmd(MODE_CHECK, '0, 0, 0, 0, 1'b0, '0);
        foreach (row_mask_mem[i]) row_mask_mem[i] = '1;
        foreach (busy_until_mem[i]) busy_until_mem[i] = '0;
        cost_reg[REG_MASK_COST]       = 9'd1;
        cost_reg[REG_ARRAY_READ_ROW]  = 9'd16;
        cost_reg[REG_ARRAY_READ_BUS]  = 9'd4;
        cost_reg[REG_MOVE_SINGLE]     = 9'd17;
        cost_reg[REG_READ_SINGLE]     = 9'd1;
        cost_reg[REG_WRITE_SINGLE]    = 9'd1;
        cost_reg[REG_WRITE_MULTI_ROW] = 9'd1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_costs();
        test_zero_costs();
        test_max_costs();
        test_random_phase(18, 200);
        test_random_phase(54, 200);
        test_random_phase(0, 200);
        test_time_saturation();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== pim_group_busy_tracker_unit.f =====
rtl/pgbt_pkg.sv
rtl/pgbt_ram.sv
rtl/pgbt_ctrl.sv
rtl/pgbt_datapath.sv
rtl/pim_group_busy_tracker_unit.sv
test/pim_group_busy_tracker_unit_tb.sv
